@@ rtl/core/bmde_pkg.sv @@
// Shared types, constants and the seven-segment table for the battery meter display encoder.
// No dependencies; imported by bmde_word and battery_meter_display_encoder_core.
package bmde_pkg;

    localparam int MV_W     = 16;
    localparam int STATUS_W = 8;
    localparam int WORD_W   = 29;
    localparam int SEG_W    = 7;
    localparam int PCT_W    = 7;
    localparam int CV_W     = 10;
    localparam int DIGIT_W  = 4;
    localparam int MAG_W    = 15;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // Percent scale: (mV - 3000) / 8, clamped to 0..100
    localparam logic [MAG_W-1:0] MV_OFFSET = 15'd3000;
    localparam int               PCT_SHIFT = 3;
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;

    // Volts scale: centivolts = (mV + 5) / 10, saturated at 999
    localparam logic [13:0]      MV_ROUND   = 14'd5;
    localparam logic [MAG_W-1:0] MV_CV_SAT  = 15'd9995;
    localparam logic [CV_W-1:0]  CV_MAX     = 10'd999;
    localparam logic [15:0]      RECIP10_MV = 16'd52429;   // 2^19 / 10, rounded up
    localparam int               RECIP10_MV_SHIFT = 19;

    // Digit split of values below 1000
    localparam logic [7:0] RECIP10_SMALL  = 8'd205;        // 2^11 / 10, rounded up
    localparam logic [5:0] RECIP100_SMALL = 6'd41;         // 2^12 / 100, rounded up

    // Display word bit positions
    localparam int BAR5_BIT    = 28;
    localparam int BAR30_BIT   = 27;
    localparam int BAR50_BIT   = 26;
    localparam int BAR70_BIT   = 25;
    localparam int BAR90_BIT   = 24;
    localparam int PCT_BIT     = 23;
    localparam int VOLT_BIT    = 22;
    localparam int DP_BIT      = 21;

    localparam logic [PCT_W-1:0] BAR5_TH  = 7'd5;
    localparam logic [PCT_W-1:0] BAR30_TH = 7'd30;
    localparam logic [PCT_W-1:0] BAR50_TH = 7'd50;
    localparam logic [PCT_W-1:0] BAR70_TH = 7'd70;
    localparam logic [PCT_W-1:0] BAR90_TH = 7'd90;
    localparam logic [PCT_W-1:0] PCT_TWO_DIGIT = 7'd10;

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic [CV_W-1:0]  cv;
        logic             pct_mode;
    } bmde_meas_t;

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'b0111111;
            4'd1:    s = 7'b0000011;
            4'd2:    s = 7'b1101101;
            4'd3:    s = 7'b1100111;
            4'd4:    s = 7'b1010011;
            4'd5:    s = 7'b1110110;
            4'd6:    s = 7'b1111110;
            4'd7:    s = 7'b0100011;
            4'd8:    s = 7'b1111111;
            4'd9:    s = 7'b1110111;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/battery_meter_display_encoder_core.sv @@
// Battery meter display encoder, top level: three-register pipeline and held display word.
// Depends on bmde_pkg and bmde_word.
//
//  Channel  | Direction | tdata (low bit first)                       | tuser
//  s_axis   | in        | voltage_mv[15:0], status_bits[23:16]        | -
//  m_axis   | out       | display_word[28:0], zero fill [31:29]       | wiring_error
//
// Each beat passes the input, measure and output registers; one beat per cycle is sustained
// while the output does not stall. The scaling multiply sits between the input and measure
// registers, the digit split and word build between the measure and output registers.
// Reset clears the held display word to zero and empties the pipeline.
// A stalled output holds its beat; each stage refills as soon as the one ahead frees up.
module battery_meter_display_encoder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bmde_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // voltage_mv, status_bits
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bmde_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // display_word, zero fill
    output logic                                m_axis_tuser    // wiring_error
);
    import bmde_pkg::*;

    logic              in_valid_reg;
    logic [MV_W-1:0]   mv_reg;
    logic              mode_reg;
    logic              meas_valid_reg;
    bmde_meas_t        meas_reg;
    bmde_meas_t        meas_next;
    logic              meas_err_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] shown_display_reg;
    logic [WORD_W-1:0] shown_display_next;
    logic              wiring_error_reg;

    logic              out_take;
    logic              meas_take;
    logic              in_take;
    logic [WORD_W-1:0] built_word;

    logic [MAG_W-1:0]  mv_mag;
    logic [MAG_W-1:0]  mv_over;
    logic [11:0]       pct_raw;
    logic [13:0]       rnd_mv;
    logic [29:0]       cv_prod;

    assign out_take  = !out_valid_reg || m_axis_tready;
    assign meas_take = !meas_valid_reg || out_take;
    assign in_take   = !in_valid_reg || meas_take;

    assign s_axis_tready = in_take;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-WORD_W){1'b0}}, shown_display_reg};
    assign m_axis_tuser  = wiring_error_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && s_axis_tvalid)
        begin
            mv_reg   <= s_axis_tdata[MV_W-1:0];
            mode_reg <= s_axis_tdata[MV_W];
        end
    end

    // Percent and centivolt scaling
    assign mv_mag  = mv_reg[MAG_W-1:0];
    assign mv_over = mv_mag - MV_OFFSET;
    assign pct_raw = mv_over[MAG_W-1:PCT_SHIFT];
    assign rnd_mv  = mv_mag[13:0] + MV_ROUND;
    assign cv_prod = 30'(rnd_mv) * 30'(RECIP10_MV);

    always_comb
    begin
        meas_next.pct_mode = mode_reg;
        if (mv_mag < MV_OFFSET)
        begin
            meas_next.pct = '0;
        end
        else if (pct_raw > 12'(PCT_MAX))
        begin
            meas_next.pct = PCT_MAX;
        end
        else
        begin
            meas_next.pct = pct_raw[PCT_W-1:0];
        end
        if (mv_mag >= MV_CV_SAT)
        begin
            meas_next.cv = CV_MAX;
        end
        else
        begin
            meas_next.cv = cv_prod[RECIP10_MV_SHIFT+CV_W-1:RECIP10_MV_SHIFT];
        end
    end

    // Measure register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_valid_reg <= 1'b0;
        end
        else if (meas_take)
        begin
            meas_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (meas_take && in_valid_reg)
        begin
            meas_reg     <= meas_next;
            meas_err_reg <= mv_reg[MV_W-1];
        end
    end

    bmde_word u_word (
        .meas (meas_reg),
        .word (built_word)
    );

    // Hold the shown word across a wiring error
    always_comb
    begin
        shown_display_next = shown_display_reg;
        if (out_take && meas_valid_reg && !meas_err_reg)
        begin
            shown_display_next = built_word;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            shown_display_reg <= '0;
        end
        else
        begin
            shown_display_reg <= shown_display_next;
            if (out_take)
            begin
                out_valid_reg <= meas_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && meas_valid_reg)
        begin
            wiring_error_reg <= meas_err_reg;
        end
    end

    // A wiring error beat leaves the shown word untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && meas_valid_reg && meas_err_reg) |=> $stable(shown_display_reg))
        else $error("shown word changed on wiring error");

    // Once a word is built, exactly one of the percent and volt signs is lit
    assert property (@(posedge clk) disable iff (!rst_n)
        (shown_display_reg != '0) |-> (shown_display_reg[PCT_BIT] ^ shown_display_reg[VOLT_BIT]))
        else $error("percent and volt signs not exclusive");

    // Decimal point follows the volt sign
    assert property (@(posedge clk) disable iff (!rst_n)
        shown_display_reg[DP_BIT] == shown_display_reg[VOLT_BIT])
        else $error("decimal point out of step with volt sign");

    // An empty measure stage never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (!meas_valid_reg) |-> s_axis_tready)
        else $error("input stalled with room in pipeline");

endmodule

@@ rtl/core/bmde_word.sv @@
// Display word builder: level bars, indicators and three seven-segment digits.
// Depends on bmde_pkg (meas struct, constants, segment table).
module bmde_word (
    input  bmde_pkg::bmde_meas_t          meas,
    output logic [bmde_pkg::WORD_W-1:0]   word
);
    import bmde_pkg::*;

    logic [17:0]        cv_p10;
    logic [15:0]        cv_p100;
    logic [6:0]         cv_q10;
    logic [DIGIT_W-1:0] cv_hund;
    logic [6:0]         cv_tens_full;
    logic [CV_W-1:0]    cv_ones_full;
    logic [14:0]        pct_p10;
    logic [DIGIT_W-1:0] pct_tens;
    logic [PCT_W-1:0]   pct_ones_full;
    logic [SEG_W-1:0]   d0;
    logic [SEG_W-1:0]   d1;
    logic [SEG_W-1:0]   d2;
    logic [4:0]         bars;

    // Reciprocal multiplies, exact for values below 1000
    assign cv_p10       = 18'(meas.cv) * 18'(RECIP10_SMALL);
    assign cv_p100      = 16'(meas.cv) * 16'(RECIP100_SMALL);
    assign cv_q10       = cv_p10[17:11];
    assign cv_hund      = cv_p100[15:12];
    assign cv_tens_full = cv_q10 - (7'(cv_hund) * 7'd10);
    assign cv_ones_full = meas.cv - (10'(cv_q10) * 10'd10);

    assign pct_p10       = 15'(meas.pct) * 15'(RECIP10_SMALL);
    assign pct_tens      = pct_p10[14:11];
    assign pct_ones_full = meas.pct - (7'(pct_tens) * 7'd10);

    assign bars = {meas.pct >= BAR5_TH, meas.pct >= BAR30_TH, meas.pct >= BAR50_TH,
                   meas.pct >= BAR70_TH, meas.pct >= BAR90_TH};

    always_comb
    begin
        if (meas.pct_mode)
        begin
            if (meas.pct == PCT_MAX)
            begin
                d0 = seg_of(4'd1);
                d1 = seg_of(4'd0);
                d2 = seg_of(4'd0);
            end
            else if (meas.pct < PCT_TWO_DIGIT)
            begin
                // blank both leading digits
                d0 = '0;
                d1 = '0;
                d2 = seg_of(pct_ones_full[DIGIT_W-1:0]);
            end
            else
            begin
                d0 = '0;
                d1 = seg_of(pct_tens);
                d2 = seg_of(pct_ones_full[DIGIT_W-1:0]);
            end
        end
        else
        begin
            d0 = seg_of(cv_hund);
            d1 = seg_of(cv_tens_full[DIGIT_W-1:0]);
            d2 = seg_of(cv_ones_full[DIGIT_W-1:0]);
        end
    end

    assign word = {bars, meas.pct_mode, !meas.pct_mode, !meas.pct_mode, d0, d1, d2};

endmodule
